@@ design/gsa_pkg.sv @@
`default_nettype none

package gsa_pkg;

    // sequence store sizes
    localparam int MAX_REF_LEN  = 1024;
    localparam int MAX_READ_LEN = 128;

    localparam int REF_AW  = $clog2(MAX_REF_LEN);
    localparam int READ_AW = $clog2(MAX_READ_LEN);
    localparam int REF_LW  = $clog2(MAX_REF_LEN + 1);
    localparam int READ_LW = $clog2(MAX_READ_LEN + 1);
    localparam int DIR_AW  = REF_AW + READ_AW;
    localparam int SCORE_W = 16;
    localparam int CFG_W   = 5;

    typedef logic [REF_LW-1:0]         t_ref_len;
    typedef logic [READ_LW-1:0]        t_read_len;
    typedef logic [REF_AW-1:0]         t_ref_addr;
    typedef logic [READ_AW-1:0]        t_read_addr;
    typedef logic [DIR_AW-1:0]         t_dir_addr;
    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [5:0]         t_delta;
    typedef logic [1:0]                t_base;
    typedef logic [1:0]                t_status;
    typedef logic [1:0]                t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_LOAD_REF  = 2'd0,
        REQ_LOAD_READ = 2'd1,
        REQ_COMPUTE   = 2'd2,
        REQ_FETCH     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        DIR_DIAG = 2'd0,
        DIR_LEFT = 2'd1,
        DIR_UP   = 2'd2
    } t_dir;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_NONE  = 2'd2;
    localparam t_status STATUS_EMPTY = 2'd3;

    localparam t_cfg_idx CFG_MATCH    = 2'd0;
    localparam t_cfg_idx CFG_MISMATCH = 2'd1;
    localparam t_cfg_idx CFG_GAP      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL_RD,
        ST_CELL_ADD,
        ST_CELL_CMP,
        ST_FETCH_RD,
        ST_FETCH_EX,
        ST_RESP
    } t_state;

    // saturating add of a small signed step to a score
    function automatic t_score sat_add(input t_score a, input t_delta b);
        logic signed [SCORE_W:0] s;
        s = (SCORE_W+1)'(a) + (SCORE_W+1)'(b);
        if (s > (SCORE_W+1)'(32767)) begin
            sat_add = 16'sh7FFF;
        end else if (s < -(SCORE_W+1)'(32768)) begin
            sat_add = 16'sh8000;
        end else begin
            sat_add = s[SCORE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/global_sequence_alignment_unit.sv @@
`default_nettype none

// channel   handshake                 payload
// -------   -----------------------   ------------------------------------------
// in        i_in_valid / o_in_stall   i_req_type, i_base, i_first
// out       o_out_valid / i_out_stall o_status, o_score, o_ref_base, o_read_base,
//                                     o_ref_present, o_read_present, o_last
// cfg       i_cfg_wr_en               i_cfg_idx, i_cfg_data
//
// load, empty compute and idle fetch: idle to response stage; input stalls until done
// fetch: direction and base memories read, then decode, then response
// compute: row 0 init, then per row a row step and per cell three steps
//   of the shared cell unit (read, add, compare and write)
// reset is synchronous active low: clears lengths and traceback, restores default scores
// a result that meets a stalled output waits in the response stage and the input stalls

module global_sequence_alignment_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // input channel
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire  [1:0]                 i_req_type,
    input  wire  [1:0]                 i_base,
    input  wire                        i_first,
    // output channel
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [1:0]                 o_status,
    output logic signed [15:0]         o_score,
    output logic [1:0]                 o_ref_base,
    output logic [1:0]                 o_read_base,
    output logic                       o_ref_present,
    output logic                       o_read_present,
    output logic                       o_last,
    // configuration
    input  wire                        i_cfg_wr_en,
    input  wire  [1:0]                 i_cfg_idx,
    input  wire  [gsa_pkg::CFG_W-1:0]  i_cfg_data
);

    // control state
    gsa_pkg::t_state    r_state, n_state;
    gsa_pkg::t_ref_len  r_ref_len;
    gsa_pkg::t_read_len r_read_len;
    gsa_pkg::t_ref_len  r_trace_row;
    gsa_pkg::t_read_len r_trace_col;
    logic               r_trace_active;
    logic               r_out_valid;

    // scoring registers
    logic [3:0]         r_match;
    logic signed [4:0]  r_mismatch;
    logic signed [4:0]  r_gap;

    // sequencer counters: row i and column j, both counted from 1
    gsa_pkg::t_ref_len  r_i;
    gsa_pkg::t_read_len r_j;

    // cell unit registers
    gsa_pkg::t_score    r_left;    // score of cell (i, j-1)
    gsa_pkg::t_score    r_diag;    // previous row score at j-1
    gsa_pkg::t_score    r_old;     // previous row score at j, next diagonal
    gsa_pkg::t_score    r_col0;    // column 0 of the current row
    gsa_pkg::t_score    r_up;
    gsa_pkg::t_score    r_lf;
    gsa_pkg::t_score    r_dg;

    // pending result
    gsa_pkg::t_status   r_res_status;
    gsa_pkg::t_score    r_res_score;
    gsa_pkg::t_base     r_res_ref_base;
    gsa_pkg::t_base     r_res_read_base;
    logic               r_res_ref_present;
    logic               r_res_read_present;
    logic               r_res_last;

    // output register
    gsa_pkg::t_status   r_out_status;
    gsa_pkg::t_score    r_out_score;
    gsa_pkg::t_base     r_out_ref_base;
    gsa_pkg::t_base     r_out_read_base;
    logic               r_out_ref_present;
    logic               r_out_read_present;
    logic               r_out_last;

    // memories and their registered read data
    gsa_pkg::t_base     r_ref_mem  [0:(1<<gsa_pkg::REF_AW)-1];
    gsa_pkg::t_base     r_read_mem [0:(1<<gsa_pkg::READ_AW)-1];
    gsa_pkg::t_score    r_score_mem[0:(1<<gsa_pkg::READ_AW)-1];
    gsa_pkg::t_dir      r_dir_mem  [0:(1<<gsa_pkg::DIR_AW)-1];
    gsa_pkg::t_base     r_ref_q;
    gsa_pkg::t_base     r_read_q;
    gsa_pkg::t_score    r_score_q;
    gsa_pkg::t_dir      r_dir_q;

    // combinational
    logic                    in_accept;
    logic                    out_free;
    gsa_pkg::t_ref_len       ref_eff;
    gsa_pkg::t_read_len      read_eff;
    logic                    ref_full;
    logic                    read_full;
    logic                    fetch_none;
    logic                    last_col;
    logic                    last_row;
    gsa_pkg::t_ref_len       i_m1;
    gsa_pkg::t_read_len      j_m1;
    gsa_pkg::t_ref_len       tr_m1;
    gsa_pkg::t_read_len      tc_m1;
    gsa_pkg::t_delta         gap_d;
    gsa_pkg::t_delta         diag_d;
    gsa_pkg::t_score         init_val;
    gsa_pkg::t_score         row0_val;
    gsa_pkg::t_score         best;
    gsa_pkg::t_dir           best_dir;
    gsa_pkg::t_dir           fetch_dir;
    gsa_pkg::t_ref_len       fetch_row;
    gsa_pkg::t_read_len      fetch_col;
    logic                    fetch_last;
    logic                    ref_we, ref_re;
    gsa_pkg::t_ref_addr      ref_raddr;
    logic                    read_we, read_re;
    gsa_pkg::t_read_addr     read_raddr;
    logic                    score_we, score_re;
    gsa_pkg::t_score         score_wdata;
    logic                    dir_we, dir_re;
    gsa_pkg::t_dir_addr      dir_waddr, dir_raddr;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign ref_eff   = i_first ? '0 : r_ref_len;
    assign read_eff  = i_first ? '0 : r_read_len;
    assign ref_full  = ref_eff >= gsa_pkg::t_ref_len'(gsa_pkg::MAX_REF_LEN);
    assign read_full = read_eff >= gsa_pkg::t_read_len'(gsa_pkg::MAX_READ_LEN);
    assign fetch_none = !r_trace_active || (r_trace_row == '0 && r_trace_col == '0);

    assign last_col = r_j == r_read_len;
    assign last_row = r_i == r_ref_len;

    assign i_m1  = r_i - gsa_pkg::t_ref_len'(1);
    assign j_m1  = r_j - gsa_pkg::t_read_len'(1);
    assign tr_m1 = r_trace_row - gsa_pkg::t_ref_len'(1);
    assign tc_m1 = r_trace_col - gsa_pkg::t_read_len'(1);

    // score steps widened to the adder operand
    assign gap_d  = gsa_pkg::t_delta'(r_gap);
    assign diag_d = (r_ref_q == r_read_q) ? gsa_pkg::t_delta'({2'b00, r_match})
                                          : gsa_pkg::t_delta'(r_mismatch);

    assign init_val = gsa_pkg::sat_add(r_left, gap_d);
    assign row0_val = gsa_pkg::sat_add(r_col0, gap_d);

    // cell choice: left only if strictly above up and not below diagonal,
    // up wins ties against diagonal
    always_comb begin
        if (r_lf > r_up) begin
            if (r_lf >= r_dg) begin
                best     = r_lf;
                best_dir = gsa_pkg::DIR_LEFT;
            end else begin
                best     = r_dg;
                best_dir = gsa_pkg::DIR_DIAG;
            end
        end else begin
            if (r_up >= r_dg) begin
                best     = r_up;
                best_dir = gsa_pkg::DIR_UP;
            end else begin
                best     = r_dg;
                best_dir = gsa_pkg::DIR_DIAG;
            end
        end
    end

    // traceback step: row 0 steps left, column 0 steps up
    always_comb begin
        if (r_trace_row == '0) begin
            fetch_dir = gsa_pkg::DIR_LEFT;
        end else if (r_trace_col == '0) begin
            fetch_dir = gsa_pkg::DIR_UP;
        end else begin
            fetch_dir = r_dir_q;
        end
        fetch_row = r_trace_row;
        fetch_col = r_trace_col;
        case (fetch_dir)
            gsa_pkg::DIR_LEFT: begin
                fetch_col = tc_m1;
            end
            gsa_pkg::DIR_UP: begin
                fetch_row = tr_m1;
            end
            default: begin
                fetch_row = tr_m1;
                fetch_col = tc_m1;
            end
        endcase
        fetch_last = (fetch_row == '0) && (fetch_col == '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (i_req_type)
                        gsa_pkg::REQ_COMPUTE: begin
                            if (r_ref_len == '0 || r_read_len == '0) begin
                                n_state = gsa_pkg::ST_RESP;
                            end else begin
                                n_state = gsa_pkg::ST_INIT;
                            end
                        end
                        gsa_pkg::REQ_FETCH: begin
                            n_state = fetch_none ? gsa_pkg::ST_RESP : gsa_pkg::ST_FETCH_RD;
                        end
                        default: begin
                            n_state = gsa_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            gsa_pkg::ST_INIT: begin
                if (last_col) begin
                    n_state = gsa_pkg::ST_ROW;
                end
            end
            gsa_pkg::ST_ROW:      n_state = gsa_pkg::ST_CELL_RD;
            gsa_pkg::ST_CELL_RD:  n_state = gsa_pkg::ST_CELL_ADD;
            gsa_pkg::ST_CELL_ADD: n_state = gsa_pkg::ST_CELL_CMP;
            gsa_pkg::ST_CELL_CMP: begin
                if (!last_col) begin
                    n_state = gsa_pkg::ST_CELL_RD;
                end else if (last_row) begin
                    n_state = gsa_pkg::ST_RESP;
                end else begin
                    n_state = gsa_pkg::ST_ROW;
                end
            end
            gsa_pkg::ST_FETCH_RD: n_state = gsa_pkg::ST_FETCH_EX;
            gsa_pkg::ST_FETCH_EX: n_state = gsa_pkg::ST_RESP;
            gsa_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = gsa_pkg::ST_IDLE;
                end
            end
            default: n_state = gsa_pkg::ST_IDLE;
        endcase
    end

    // handshake and memory port controls
    always_comb begin
        o_in_stall  = r_state != gsa_pkg::ST_IDLE;
        ref_we      = in_accept && (i_req_type == gsa_pkg::REQ_LOAD_REF) && !ref_full;
        read_we     = in_accept && (i_req_type == gsa_pkg::REQ_LOAD_READ) && !read_full;
        ref_re      = 1'b0;
        read_re     = 1'b0;
        score_re    = 1'b0;
        score_we    = 1'b0;
        dir_re      = 1'b0;
        dir_we      = 1'b0;
        ref_raddr   = tr_m1[gsa_pkg::REF_AW-1:0];
        read_raddr  = tc_m1[gsa_pkg::READ_AW-1:0];
        score_wdata = best;
        dir_raddr   = {tr_m1[gsa_pkg::REF_AW-1:0], tc_m1[gsa_pkg::READ_AW-1:0]};
        dir_waddr   = {i_m1[gsa_pkg::REF_AW-1:0], j_m1[gsa_pkg::READ_AW-1:0]};
        case (r_state)
            gsa_pkg::ST_INIT: begin
                score_we    = 1'b1;
                score_wdata = init_val;
            end
            gsa_pkg::ST_ROW: begin
                ref_re    = 1'b1;
                ref_raddr = i_m1[gsa_pkg::REF_AW-1:0];
            end
            gsa_pkg::ST_CELL_RD: begin
                read_re    = 1'b1;
                score_re   = 1'b1;
                read_raddr = j_m1[gsa_pkg::READ_AW-1:0];
            end
            gsa_pkg::ST_CELL_CMP: begin
                score_we = 1'b1;
                dir_we   = 1'b1;
            end
            gsa_pkg::ST_FETCH_RD: begin
                ref_re  = 1'b1;
                read_re = 1'b1;
                dir_re  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequence, score row and direction memories
    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            r_ref_mem[ref_eff[gsa_pkg::REF_AW-1:0]] <= i_base;
        end
        if (ref_re) begin
            r_ref_q <= r_ref_mem[ref_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (read_we) begin
            r_read_mem[read_eff[gsa_pkg::READ_AW-1:0]] <= i_base;
        end
        if (read_re) begin
            r_read_q <= r_read_mem[read_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (score_we) begin
            r_score_mem[j_m1[gsa_pkg::READ_AW-1:0]] <= score_wdata;
        end
        if (score_re) begin
            r_score_q <= r_score_mem[j_m1[gsa_pkg::READ_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_waddr] <= best_dir;
        end
        if (dir_re) begin
            r_dir_q <= r_dir_mem[dir_raddr];
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gsa_pkg::ST_IDLE;
            r_ref_len      <= '0;
            r_read_len     <= '0;
            r_trace_row    <= '0;
            r_trace_col    <= '0;
            r_trace_active <= 1'b0;
            r_out_valid    <= 1'b0;
            r_match        <= 4'd1;
            r_mismatch     <= -5'sd1;
            r_gap          <= -5'sd2;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    gsa_pkg::CFG_MATCH:    r_match    <= i_cfg_data[3:0];
                    gsa_pkg::CFG_MISMATCH: r_mismatch <= i_cfg_data;
                    gsa_pkg::CFG_GAP:      r_gap      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                gsa_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_res_status       <= gsa_pkg::STATUS_OK;
                        r_res_score        <= '0;
                        r_res_ref_base     <= '0;
                        r_res_read_base    <= '0;
                        r_res_ref_present  <= 1'b0;
                        r_res_read_present <= 1'b0;
                        r_res_last         <= 1'b0;
                        r_i                <= gsa_pkg::t_ref_len'(1);
                        r_j                <= gsa_pkg::t_read_len'(1);
                        r_left             <= '0;
                        r_col0             <= '0;
                        case (i_req_type)
                            gsa_pkg::REQ_LOAD_REF: begin
                                r_trace_active <= 1'b0;
                                if (ref_full) begin
                                    r_ref_len    <= ref_eff;
                                    r_res_status <= gsa_pkg::STATUS_FULL;
                                end else begin
                                    r_ref_len <= ref_eff + gsa_pkg::t_ref_len'(1);
                                end
                            end
                            gsa_pkg::REQ_LOAD_READ: begin
                                r_trace_active <= 1'b0;
                                if (read_full) begin
                                    r_read_len   <= read_eff;
                                    r_res_status <= gsa_pkg::STATUS_FULL;
                                end else begin
                                    r_read_len <= read_eff + gsa_pkg::t_read_len'(1);
                                end
                            end
                            gsa_pkg::REQ_COMPUTE: begin
                                if (r_ref_len == '0 || r_read_len == '0) begin
                                    r_trace_active <= 1'b0;
                                    r_res_status   <= gsa_pkg::STATUS_EMPTY;
                                end
                            end
                            default: begin
                                if (fetch_none) begin
                                    r_trace_active <= 1'b0;
                                    r_res_status   <= gsa_pkg::STATUS_NONE;
                                end
                            end
                        endcase
                    end
                end
                gsa_pkg::ST_INIT: begin
                    // row 0: running sum of gap steps
                    r_left <= init_val;
                    r_j    <= last_col ? gsa_pkg::t_read_len'(1)
                                       : r_j + gsa_pkg::t_read_len'(1);
                end
                gsa_pkg::ST_ROW: begin
                    r_diag <= r_col0;
                    r_col0 <= row0_val;
                    r_left <= row0_val;
                end
                gsa_pkg::ST_CELL_ADD: begin
                    r_up  <= gsa_pkg::sat_add(r_score_q, gap_d);
                    r_lf  <= gsa_pkg::sat_add(r_left, gap_d);
                    r_dg  <= gsa_pkg::sat_add(r_diag, diag_d);
                    r_old <= r_score_q;
                end
                gsa_pkg::ST_CELL_CMP: begin
                    r_left <= best;
                    r_diag <= r_old;
                    if (last_col) begin
                        r_j <= gsa_pkg::t_read_len'(1);
                        if (last_row) begin
                            r_res_score    <= best;
                            r_trace_row    <= r_ref_len;
                            r_trace_col    <= r_read_len;
                            r_trace_active <= 1'b1;
                        end else begin
                            r_i <= r_i + gsa_pkg::t_ref_len'(1);
                        end
                    end else begin
                        r_j <= r_j + gsa_pkg::t_read_len'(1);
                    end
                end
                gsa_pkg::ST_FETCH_EX: begin
                    case (fetch_dir)
                        gsa_pkg::DIR_LEFT: begin
                            r_res_read_base    <= r_read_q;
                            r_res_read_present <= 1'b1;
                        end
                        gsa_pkg::DIR_UP: begin
                            r_res_ref_base    <= r_ref_q;
                            r_res_ref_present <= 1'b1;
                        end
                        default: begin
                            r_res_ref_base     <= r_ref_q;
                            r_res_read_base    <= r_read_q;
                            r_res_ref_present  <= 1'b1;
                            r_res_read_present <= 1'b1;
                        end
                    endcase
                    r_trace_row    <= fetch_row;
                    r_trace_col    <= fetch_col;
                    r_res_last     <= fetch_last;
                    r_trace_active <= !fetch_last;
                end
                default: begin
                end
            endcase

            // output register: loads from the pending result once free
            if (r_state == gsa_pkg::ST_RESP && out_free) begin
                r_out_valid        <= 1'b1;
                r_out_status       <= r_res_status;
                r_out_score        <= r_res_score;
                r_out_ref_base     <= r_res_ref_base;
                r_out_read_base    <= r_res_read_base;
                r_out_ref_present  <= r_res_ref_present;
                r_out_read_present <= r_res_read_present;
                r_out_last         <= r_res_last;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_score        = r_out_score;
    assign o_ref_base     = r_out_ref_base;
    assign o_read_base    = r_out_read_base;
    assign o_ref_present  = r_out_ref_present;
    assign o_read_present = r_out_read_present;
    assign o_last         = r_out_last;

    // every accepted item leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != gsa_pkg::ST_IDLE)
        else $error("accepted item did not start work");

    // traceback position stays inside the loaded matrix
    a_trace_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trace_active |-> (r_trace_row <= r_ref_len) && (r_trace_col <= r_read_len))
        else $error("traceback position beyond sequence lengths");

    // cell counters stay inside the matrix while filling
    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsa_pkg::ST_CELL_RD || r_state == gsa_pkg::ST_CELL_CMP)
        |-> (r_i != '0) && (r_i <= r_ref_len) && (r_j != '0) && (r_j <= r_read_len))
        else $error("cell counter out of range");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid && $stable(r_out_status)
        && $stable(r_out_score) && $stable(r_out_last))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ dv/global_sequence_alignment_unit_tb.sv @@
`timescale 1ns / 100ps

module global_sequence_alignment_unit_tb;

    localparam int                RUN_LIMIT    = 1500000;
    localparam int                RANDOM_ITEMS = 50;
    localparam gsa_pkg::t_cfg_idx CFG_UNUSED   = 2'd3;

    // one input item as offered on the input channel
    typedef struct packed {
        gsa_pkg::t_req  req;
        gsa_pkg::t_base base;
        logic           first;
    } t_align_req;

    // one result item: load status, score answer or traceback column
    typedef struct packed {
        gsa_pkg::t_status status;
        gsa_pkg::t_score  score;
        gsa_pkg::t_base   ref_base;
        gsa_pkg::t_base   read_base;
        logic             ref_present;
        logic             read_present;
        logic             last;
    } t_column;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } t_stall_mode;

    // dut ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_req_type     = 2'd0;
    logic [1:0]        i_base         = 2'd0;
    logic              i_first        = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [1:0]        o_status;
    logic signed [15:0] o_score;
    logic [1:0]        o_ref_base;
    logic [1:0]        o_read_base;
    logic              o_ref_present;
    logic              o_read_present;
    logic              o_last;
    logic              i_cfg_wr_en    = 1'b0;
    logic [1:0]        i_cfg_idx      = 2'd0;
    logic [gsa_pkg::CFG_W-1:0] i_cfg_data = '0;

    global_sequence_alignment_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_base         (i_base),
        .i_first        (i_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_score        (o_score),
        .o_ref_base     (o_ref_base),
        .o_read_base    (o_read_base),
        .o_ref_present  (o_ref_present),
        .o_read_present (o_read_present),
        .o_last         (o_last),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // items waiting to be offered, and answers still owed by the block
    t_align_req request_q[$];
    t_column    predicted_columns[$];

    // alignment state mirrored from the block
    int             nw_match    = 1;
    int             nw_mismatch = -1;
    int             nw_gap      = -2;
    gsa_pkg::t_base ref_seq [gsa_pkg::MAX_REF_LEN];
    gsa_pkg::t_base read_seq [gsa_pkg::MAX_READ_LEN];
    int             ref_count   = 0;
    int             read_count  = 0;
    int             score_line [gsa_pkg::MAX_READ_LEN+1];
    gsa_pkg::t_dir  trace_dirs [gsa_pkg::MAX_REF_LEN*gsa_pkg::MAX_READ_LEN];
    int             walk_row    = 0;
    int             walk_col    = 0;
    bit             walk_on     = 1'b0;

    // sequence lengths as seen by the stimulus side, used to size tracebacks
    int gen_ref_len  = 0;
    int gen_read_len = 0;

    // bookkeeping
    int queued_total    = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int computes_done   = 0;
    int columns_done    = 0;
    int loads_dropped   = 0;
    int null_answers    = 0;
    int cycle_count     = 0;

    // driver pacing
    int burst_left  = 1;
    int gap_left    = 0;
    int drive_tick  = 0;
    bit sender_calm = 1'b0;

    // receiver pacing
    int          hold_left  = 0;
    int          stall_tick = 0;
    t_stall_mode stall_mode = STALL_NONE;

    function automatic int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // one step of linear-gap global alignment: load, fill the matrix, or walk back one column
    function automatic t_column nw_align_step(t_align_req q);
        t_column       r;
        int            diag;
        int            up;
        int            left;
        int            dg;
        int            best;
        gsa_pkg::t_dir d;
        r = '0;
        case (q.req)
            gsa_pkg::REQ_LOAD_REF: begin
                walk_on = 1'b0;
                if (q.first) ref_count = 0;
                if (ref_count < gsa_pkg::MAX_REF_LEN) begin
                    ref_seq[ref_count] = q.base;
                    ref_count++;
                end else begin
                    r.status = gsa_pkg::STATUS_FULL;
                    loads_dropped++;
                end
            end
            gsa_pkg::REQ_LOAD_READ: begin
                walk_on = 1'b0;
                if (q.first) read_count = 0;
                if (read_count < gsa_pkg::MAX_READ_LEN) begin
                    read_seq[read_count] = q.base;
                    read_count++;
                end else begin
                    r.status = gsa_pkg::STATUS_FULL;
                    loads_dropped++;
                end
            end
            gsa_pkg::REQ_COMPUTE: begin
                if (ref_count == 0 || read_count == 0) begin
                    walk_on  = 1'b0;
                    r.status = gsa_pkg::STATUS_EMPTY;
                    null_answers++;
                end else begin
                    score_line[0] = 0;
                    for (int j = 1; j <= read_count; j++)
                        score_line[j] = clip16(score_line[j-1] + nw_gap);
                    for (int i = 1; i <= ref_count; i++) begin
                        diag          = score_line[0];
                        score_line[0] = clip16(score_line[0] + nw_gap);
                        for (int j = 1; j <= read_count; j++) begin
                            up   = clip16(score_line[j] + nw_gap);
                            left = clip16(score_line[j-1] + nw_gap);
                            dg   = clip16(diag + ((ref_seq[i-1] == read_seq[j-1]) ?
                                                  nw_match : nw_mismatch));
                            // left needs a strict win over up; gaps win ties with diagonal
                            if (left > up) begin
                                if (left >= dg) begin
                                    best = left;
                                    d    = gsa_pkg::DIR_LEFT;
                                end else begin
                                    best = dg;
                                    d    = gsa_pkg::DIR_DIAG;
                                end
                            end else begin
                                if (up >= dg) begin
                                    best = up;
                                    d    = gsa_pkg::DIR_UP;
                                end else begin
                                    best = dg;
                                    d    = gsa_pkg::DIR_DIAG;
                                end
                            end
                            diag          = score_line[j];
                            score_line[j] = best;
                            trace_dirs[(i-1)*gsa_pkg::MAX_READ_LEN + (j-1)] = d;
                        end
                    end
                    walk_row = ref_count;
                    walk_col = read_count;
                    walk_on  = 1'b1;
                    r.score  = gsa_pkg::t_score'(score_line[read_count]);
                    computes_done++;
                end
            end
            default: begin
                if (!walk_on || (walk_row == 0 && walk_col == 0)) begin
                    walk_on  = 1'b0;
                    r.status = gsa_pkg::STATUS_NONE;
                    null_answers++;
                end else begin
                    // top row only goes left, left column only goes up
                    if (walk_row == 0) d = gsa_pkg::DIR_LEFT;
                    else if (walk_col == 0) d = gsa_pkg::DIR_UP;
                    else d = trace_dirs[(walk_row-1)*gsa_pkg::MAX_READ_LEN + (walk_col-1)];
                    if (d != gsa_pkg::DIR_UP) begin
                        r.read_base    = read_seq[walk_col-1];
                        r.read_present = 1'b1;
                        walk_col--;
                    end
                    if (d != gsa_pkg::DIR_LEFT) begin
                        r.ref_base    = ref_seq[walk_row-1];
                        r.ref_present = 1'b1;
                        walk_row--;
                    end
                    if (walk_row == 0 && walk_col == 0) begin
                        r.last  = 1'b1;
                        walk_on = 1'b0;
                    end
                    columns_done++;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input driver: bursts with random gaps, calm stretches with no gaps
    always @(posedge i_clk) begin : drive
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted_columns.insert(predicted_columns.size(),
                                         nw_align_step(request_q[0]));
                void'(request_q.pop_front());
                items_sent++;
            end
            drive_tick++;
            if (drive_tick % 256 == 0) sender_calm = ($urandom_range(0, 2) == 0);
            // a stalled item holds its payload
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_req_type <= request_q[0].req;
                    i_base     <= request_q[0].base;
                    i_first    <= request_q[0].first;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = sender_calm ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stall pattern
    always @(posedge i_clk) begin : watch
        t_column want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_columns.size() == 0) begin
                $error("result with nothing expected: status %0d score %0d",
                       o_status, o_score);
                mismatches++;
            end else begin
                want = predicted_columns.pop_front();
                check_field("status", want.status, o_status);
                check_field("score", int'(want.score), int'(o_score));
                check_field("ref_base", want.ref_base, o_ref_base);
                check_field("read_base", want.read_base, o_read_base);
                check_field("ref_present", want.ref_present, o_ref_present);
                check_field("read_present", want.read_present, o_read_present);
                check_field("last", want.last, o_last);
            end
            results_checked++;
            // long hold-off so the block backs up and stalls its input
            if (results_checked % 700 == 60) hold_left = 400;
        end
        stall_tick++;
        if (stall_tick % 128 == 0) stall_mode = t_stall_mode'($urandom_range(0, 3));
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= stall_tick[2];
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL global_sequence_alignment_unit");
            $finish;
        end
    end

    function automatic void push_item(gsa_pkg::t_req r, gsa_pkg::t_base b, logic f);
        t_align_req it;
        it.req   = r;
        it.base  = b;
        it.first = f;
        request_q.insert(request_q.size(), it);
        queued_total++;
        if (r == gsa_pkg::REQ_LOAD_REF) begin
            if (f) gen_ref_len = 0;
            if (gen_ref_len < gsa_pkg::MAX_REF_LEN) gen_ref_len++;
        end else if (r == gsa_pkg::REQ_LOAD_READ) begin
            if (f) gen_read_len = 0;
            if (gen_read_len < gsa_pkg::MAX_READ_LEN) gen_read_len++;
        end
    endfunction

    // a fresh sequence of n random bases
    function automatic void push_load(gsa_pkg::t_req r, int n);
        for (int k = 0; k < n; k++)
            push_item(r, gsa_pkg::t_base'($urandom_range(0, 3)), k == 0);
    endfunction

    // compute and fetch carry don't-care base and first
    function automatic void push_op(gsa_pkg::t_req r);
        push_item(r, gsa_pkg::t_base'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void push_noise(int n);
        repeat (n) push_item(gsa_pkg::t_req'($urandom_range(0, 3)),
                             gsa_pkg::t_base'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)));
    endfunction

    // reload (length 0 keeps the stored sequence), align, then fetch part, all or beyond the path
    function automatic void queue_alignment(int rlen, int qlen, bit full_walk);
        int lo;
        int hi;
        int nfetch;
        if (rlen > 0) push_load(gsa_pkg::REQ_LOAD_REF, rlen);
        if (qlen > 0) push_load(gsa_pkg::REQ_LOAD_READ, qlen);
        if (!full_walk && $urandom_range(0, 5) == 0) push_noise(1);
        push_op(gsa_pkg::REQ_COMPUTE);
        lo = (gen_ref_len > gen_read_len) ? gen_ref_len : gen_read_len;
        hi = gen_ref_len + gen_read_len;
        if (full_walk) nfetch = hi + 2;
        else begin
            case ($urandom_range(0, 4))
                0:       nfetch = $urandom_range(0, lo);
                1, 2:    nfetch = hi + $urandom_range(1, 2);
                default: nfetch = $urandom_range(lo, hi);
            endcase
        end
        repeat (nfetch) push_op(gsa_pkg::REQ_FETCH);
    endfunction

    // every answer in, then the block's own latency
    task automatic wait_idle();
        while (request_q.size() != 0 || predicted_columns.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // called at a clock edge with the block idle
    task automatic write_reg(gsa_pkg::t_cfg_idx idx, int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= gsa_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            gsa_pkg::CFG_MATCH:    nw_match    = value & 15;
            gsa_pkg::CFG_MISMATCH: nw_mismatch = int'($signed(gsa_pkg::CFG_W'(value)));
            gsa_pkg::CFG_GAP:      nw_gap      = int'($signed(gsa_pkg::CFG_W'(value)));
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int random_from;
        int rl;
        int ql;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset scores
        push_item(gsa_pkg::REQ_FETCH, 2'd3, 1'b1);        // fetch with no traceback
        push_item(gsa_pkg::REQ_COMPUTE, 2'd2, 1'b1);      // both sequences empty
        push_item(gsa_pkg::REQ_LOAD_REF, 2'd3, 1'b1);
        push_item(gsa_pkg::REQ_LOAD_REF, 2'd0, 1'b0);
        push_item(gsa_pkg::REQ_COMPUTE, 2'd0, 1'b0);      // read still empty
        push_item(gsa_pkg::REQ_LOAD_READ, 2'd2, 1'b1);
        push_item(gsa_pkg::REQ_LOAD_READ, 2'd1, 1'b0);
        push_item(gsa_pkg::REQ_LOAD_READ, 2'd0, 1'b0);
        push_item(gsa_pkg::REQ_LOAD_REF, 2'd1, 1'b0);
        push_item(gsa_pkg::REQ_LOAD_REF, 2'd2, 1'b0);
        push_item(gsa_pkg::REQ_COMPUTE, 2'd3, 1'b1);
        repeat (3) push_item(gsa_pkg::REQ_FETCH, 2'd1, 1'b0);
        push_item(gsa_pkg::REQ_LOAD_READ, 2'd3, 1'b0);    // load cuts the traceback short
        push_item(gsa_pkg::REQ_FETCH, 2'd0, 1'b1);
        push_item(gsa_pkg::REQ_COMPUTE, 2'd1, 1'b0);
        repeat (9) push_item(gsa_pkg::REQ_FETCH, 2'd2, 1'b1);  // 4-column walk, 5 past end
        wait_idle();

        // strongest match, harshest penalties
        write_reg(gsa_pkg::CFG_MATCH, 15);
        write_reg(gsa_pkg::CFG_MISMATCH, -15);
        write_reg(gsa_pkg::CFG_GAP, -15);
        queue_alignment(8, 8, 1'b1);
        queue_alignment(1, 1, 1'b1);
        queue_alignment(12, 3, 1'b0);
        wait_idle();

        // all zero: every cell ties, so only the tie rules decide
        write_reg(gsa_pkg::CFG_MATCH, 0);
        write_reg(gsa_pkg::CFG_MISMATCH, 0);
        write_reg(gsa_pkg::CFG_GAP, 0);
        write_reg(CFG_UNUSED, 31);
        queue_alignment(7, 4, 1'b1);
        queue_alignment(3, 9, 1'b1);
        wait_idle();

        // free gaps against costly mismatches
        write_reg(gsa_pkg::CFG_MISMATCH, -15);
        queue_alignment(6, 6, 1'b1);
        queue_alignment(0, 10, 1'b0);
        wait_idle();

        // read store overflow: the two extra bases are dropped,
        // then a full walk over the longest read
        write_reg(gsa_pkg::CFG_MATCH, 2);
        write_reg(gsa_pkg::CFG_MISMATCH, -3);
        write_reg(gsa_pkg::CFG_GAP, -1);
        push_load(gsa_pkg::REQ_LOAD_READ, gsa_pkg::MAX_READ_LEN + 2);
        queue_alignment(5, 0, 1'b1);
        wait_idle();

        // random part: random scores per phase, mostly small well-formed alignments
        random_from = queued_total;
        while (queued_total - random_from < RANDOM_ITEMS) begin
            wait_idle();
            write_reg(gsa_pkg::CFG_MATCH, $urandom_range(0, 15));
            write_reg(gsa_pkg::CFG_MISMATCH, -$urandom_range(0, 15));
            write_reg(gsa_pkg::CFG_GAP, -$urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) write_reg(CFG_UNUSED, $urandom_range(0, 31));
            repeat ($urandom_range(2, 5)) begin
                if (queued_total - random_from < RANDOM_ITEMS) begin
                    if ($urandom_range(0, 7) == 0) begin
                        push_noise($urandom_range(1, 6));
                    end else begin
                        if (gen_ref_len > 0 && $urandom_range(0, 4) == 0) rl = 0;
                        else if ($urandom_range(0, 4) == 0) rl = $urandom_range(13, 48);
                        else rl = $urandom_range(1, 12);
                        if (gen_read_len > 0 && $urandom_range(0, 4) == 0) ql = 0;
                        else if ($urandom_range(0, 4) == 0) ql = $urandom_range(9, 24);
                        else ql = $urandom_range(1, 8);
                        queue_alignment(rl, ql, 1'b0);
                    end
                end
            end
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        $display("run: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display("run: %0d alignments, %0d traceback columns, %0d dropped loads, %0d null answers",
                 computes_done, columns_done, loads_dropped, null_answers);
        if (mismatches == 0) begin
            $display("PASS global_sequence_alignment_unit");
        end else begin
            $display("FAIL global_sequence_alignment_unit");
        end
        $finish;
    end

endmodule
